// File: src/v3au_pkg.sv
package v3au_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned TRIG_FRAC = 30;
  localparam int unsigned EPS_BITS  = 16;

  // Angle reduction: |scalar| * 2^14 is at most 2^45 and two pi is above 2^32,
  // so the reduction quotient has at most 13 bits.
  localparam int unsigned ZMOD_STEPS = 13;
  localparam int unsigned ROT_STEPS  = 16;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 32;

  // Pipeline stage schedule. Paths that run side by side share stages.
  localparam int unsigned ST_IN     = 0;
  localparam int unsigned ST_PREP   = 1;
  localparam int unsigned ST_MUL    = 2;
  localparam int unsigned ST_SUM    = 3;
  localparam int unsigned ST_ZMOD0  = 2;
  localparam int unsigned ST_FOLD   = ST_ZMOD0 + ZMOD_STEPS;
  localparam int unsigned ST_CORD0  = ST_FOLD + 1;
  localparam int unsigned ST_ROTSEL = ST_CORD0 + ROT_STEPS;
  localparam int unsigned ST_ROTMUL = ST_ROTSEL + 1;
  localparam int unsigned ST_ROTSUM = ST_ROTMUL + 1;
  localparam int unsigned ST_SQRT0  = ST_SUM + 1;
  localparam int unsigned ST_DIVSET = ST_SQRT0 + SQRT_STEPS;
  localparam int unsigned ST_DIV0   = ST_DIVSET + 1;
  localparam int unsigned ST_LAST   = ST_DIV0 + DIV_STEPS;
  localparam int unsigned NST       = ST_LAST + 1;

  localparam int unsigned S_TDATA_W = 320;
  localparam int unsigned S_TUSER_W = 5;
  localparam int unsigned M_TDATA_W = 136;

  typedef logic signed [31:0] word_t;
  typedef logic signed [63:0] prod_t;
  typedef logic signed [35:0] ang_t;
  typedef logic signed [67:0] rot_t;

  typedef enum logic [4:0] {
    FN_ADD    = 5'd0,
    FN_SUB    = 5'd1,
    FN_MUL    = 5'd2,
    FN_SCALE  = 5'd3,
    FN_DIV    = 5'd4,
    FN_DIVS   = 5'd5,
    FN_DOT    = 5'd6,
    FN_CROSS  = 5'd7,
    FN_SQLEN  = 5'd8,
    FN_LEN    = 5'd9,
    FN_DIST   = 5'd10,
    FN_NORM   = 5'd11,
    FN_LERP   = 5'd12,
    FN_CLAMP  = 5'd13,
    FN_ROTXY  = 5'd14,
    FN_ROTXZ  = 5'd15,
    FN_ROTYZ  = 5'd16,
    FN_ABS    = 5'd17,
    FN_DIFF   = 5'd18,
    FN_EQUAL  = 5'd19
  } func_e;

  localparam word_t EPS_RESET = 32'sd1;
  localparam logic signed [71:0] WMAX72 = 72'sd2147483647;
  localparam logic signed [71:0] WMIN72 = -72'sd2147483648;
  localparam word_t WMAX = 32'sh7FFF_FFFF;
  localparam word_t WMIN = 32'sh8000_0000;

  localparam logic [45:0] TWO_PI_Q30  = 46'd6746518852;
  localparam ang_t        PI_Q30      = 36'sd3373259426;
  localparam ang_t        HALF_PI_Q30 = 36'sd1686629713;
  localparam ang_t        TWO_PI_A    = 36'sd6746518852;
  localparam ang_t        GAIN_Q30    = 36'sd652032874;

  localparam logic [29:0] ATAN_Q30 [32] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
    30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1024, 30'd511, 30'd256,
    30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
  };

  typedef struct packed {
    logic [4:0]        func;
    word_t [2:0]       a;
    word_t [2:0]       b;
    word_t [2:0]       c;
    word_t             s;
    word_t [2:0]       d;
    word_t [2:0]       e;
    word_t [5:0]       ma;
    word_t [5:0]       mb;
    prod_t [5:0]       p;
    word_t [2:0]       r;
    word_t             so;
    logic              eq;
    logic              guard;
    logic [63:0]       ssum;
    logic [63:0]       sroot;
    logic [45:0]       zrem;
    logic              zneg;
    ang_t              z;
    ang_t              cx;
    ang_t              cy;
    logic              flip;
    word_t             rp;
    word_t             rq;
    ang_t              cs;
    ang_t              sn;
    rot_t [3:0]        rm;
    logic [2:0][47:0]  num;
    logic [2:0][32:0]  den;
    logic [2:0]        qneg;
    logic [2:0]        ovf;
    logic [2:0][31:0]  q;
  } stage_t;

  function automatic word_t sat_w(input logic signed [71:0] v);
    word_t res;
    if (v > WMAX72) begin
      res = WMAX;
    end else if (v < WMIN72) begin
      res = WMIN;
    end else begin
      res = word_t'(v[31:0]);
    end
    return res;
  endfunction

  function automatic logic near_zero(input logic signed [32:0] v,
                                     input logic [EPS_BITS-1:0] eps);
    logic [32:0] m;
    m = v[32] ? 33'(-v) : 33'(v);
    return (m == 33'd0) || (m < 33'(eps));
  endfunction

endpackage

// File: src/vector3_arithmetic_unit_top.sv
// Three-component vector ALU on signed Q16.16 words.
// Input channel (s_axis): tuser carries the operation code, tdata carries the
// operand vectors a, b, c and the scalar. Output channel (m_axis): tdata
// carries the result vector, the scalar result and two flags. Both channels
// accept an item at a rising edge where tvalid and tready are high.
// The zero tolerance register is written through cfg_we_i/cfg_wdata_i; the user must
// write it only while the unit is idle, the block itself does not enforce it; it resets to one.
// The datapath is a 70-stage pipeline, and one item per cycle is taken for every
// operation while the receiver does not stall.
// The depth is set by the bit-per-stage square root (32 stages) followed by
// the bit-per-stage divider (32 stages); the rotation engine (angle
// reduction plus 16 CORDIC stages) runs alongside the root.
// Every stage holds a valid bit. When the receiver stalls, stages holding
// items stop but empty stages in front of them keep filling, so the input
// keeps taking items until the pipeline is full.
// Reset clears all valid bits and sets the tolerance to one; payload
// registers are not reset.
module vector3_arithmetic_unit_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [v3au_pkg::EPS_BITS-1:0]     cfg_wdata_i,   // zero_epsilon
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, scalar_in
  input  logic [v3au_pkg::S_TDATA_W-1:0]    s_axis_tdata_i,
  // func
  input  logic [v3au_pkg::S_TUSER_W-1:0]    s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // r_x, r_y, r_z, scalar_out, is_equal, zero_guard, zero padding
  output logic [v3au_pkg::M_TDATA_W-1:0]    m_axis_tdata_o
);
  import v3au_pkg::*;

  logic [EPS_BITS-1:0] eps_q;
  stage_t              st_q [NST];
  stage_t              st_d [NST];
  logic [NST-1:0]      vld_q;
  logic [NST:0]        adv;

  // One stage of work; k picks which of the parallel paths act here.
  function automatic stage_t stage_fn(input int k, input stage_t x,
                                      input logic [EPS_BITS-1:0] eps);
    stage_t              y;
    word_t [2:0]         dv;
    word_t [2:0]         ev;
    logic signed [47:0]  fp [6];
    logic signed [32:0]  s33;
    logic [32:0]         sabs;
    logic [47:0]         sq16;
    logic [45:0]         zsub;
    ang_t                za;
    ang_t                nx;
    ang_t                at;
    word_t               np;
    word_t               nq;
    logic [63:0]         bitv;
    logic [64:0]         tsum;
    logic [31:0]         len;
    logic signed [32:0]  dsg [3];
    logic [63:0]         dd;
    int                  j;
    y = x;

    if (k == ST_PREP) begin
      for (int i = 0; i < 3; i++) begin
        dv[i] = sat_w(72'(x.a[i]) - 72'(x.b[i]));
        ev[i] = sat_w(72'(x.b[i]) - 72'(x.a[i]));
      end
      y.d  = dv;
      y.e  = ev;
      y.ma = '0;
      y.mb = '0;
      unique case (func_e'(x.func))
        FN_MUL, FN_DOT: begin
          for (int i = 0; i < 3; i++) begin
            y.ma[i] = x.a[i];
            y.mb[i] = x.b[i];
          end
        end
        FN_SCALE: begin
          for (int i = 0; i < 3; i++) begin
            y.ma[i] = x.a[i];
            y.mb[i] = x.s;
          end
        end
        FN_CROSS: begin
          y.ma[0] = x.a[1]; y.mb[0] = x.b[2];
          y.ma[1] = x.a[2]; y.mb[1] = x.b[0];
          y.ma[2] = x.a[0]; y.mb[2] = x.b[1];
          y.ma[3] = x.a[2]; y.mb[3] = x.b[1];
          y.ma[4] = x.a[0]; y.mb[4] = x.b[2];
          y.ma[5] = x.a[1]; y.mb[5] = x.b[0];
        end
        FN_SQLEN, FN_LEN, FN_NORM: begin
          for (int i = 0; i < 3; i++) begin
            y.ma[i] = x.a[i];
            y.mb[i] = x.a[i];
          end
        end
        FN_DIST: begin
          for (int i = 0; i < 3; i++) begin
            y.ma[i] = dv[i];
            y.mb[i] = dv[i];
          end
        end
        FN_LERP: begin
          for (int i = 0; i < 3; i++) begin
            y.ma[i] = ev[i];
            y.mb[i] = x.s;
          end
        end
        default: begin
        end
      endcase
      s33    = 33'(x.s);
      sabs   = s33[32] ? 33'(-s33) : 33'(s33);
      y.zrem = 46'(sabs) << (TRIG_FRAC - FRAC_BITS);
      y.zneg = x.s[31];
    end

    if (k == ST_MUL) begin
      for (int i = 0; i < 6; i++) begin
        y.p[i] = 64'(x.ma[i]) * 64'(x.mb[i]);
      end
    end

    // Angle reduction modulo two pi, one quotient bit per stage.
    if (k >= ST_ZMOD0 && k < ST_ZMOD0 + ZMOD_STEPS) begin
      j    = ZMOD_STEPS - 1 - (k - ST_ZMOD0);
      zsub = TWO_PI_Q30 << j;
      if (x.zrem >= zsub) begin
        y.zrem = x.zrem - zsub;
      end
    end

    if (k == ST_SUM) begin
      for (int i = 0; i < 6; i++) begin
        fp[i] = 48'(x.p[i] >>> FRAC_BITS);
      end
      y.ssum  = 64'(x.p[0]) + 64'(x.p[1]) + 64'(x.p[2]);
      y.sroot = '0;
      y.r     = '0;
      y.so    = '0;
      y.eq    = 1'b0;
      y.guard = 1'b0;
      sq16    = 48'(y.ssum >> FRAC_BITS);
      unique case (func_e'(x.func))
        FN_ADD: begin
          for (int i = 0; i < 3; i++) y.r[i] = sat_w(72'(x.a[i]) + 72'(x.b[i]));
        end
        FN_SUB: y.r = x.d;
        FN_MUL, FN_SCALE: begin
          for (int i = 0; i < 3; i++) y.r[i] = sat_w(72'(fp[i]));
        end
        FN_DOT: y.so = sat_w(72'(fp[0]) + 72'(fp[1]) + 72'(fp[2]));
        FN_CROSS: begin
          y.r[0] = sat_w(72'(fp[0]) - 72'(fp[3]));
          y.r[1] = sat_w(72'(fp[1]) - 72'(fp[4]));
          y.r[2] = sat_w(72'(fp[2]) - 72'(fp[5]));
        end
        FN_SQLEN: y.so = (sq16 > 48'h7FFF_FFFF) ? WMAX : word_t'(sq16[31:0]);
        FN_LERP: begin
          for (int i = 0; i < 3; i++) y.r[i] = sat_w(72'(x.a[i]) + 72'(fp[i]));
        end
        FN_CLAMP: begin
          for (int i = 0; i < 3; i++) begin
            y.r[i] = (x.a[i] < x.b[i]) ? x.b[i] :
                     ((x.a[i] > x.c[i]) ? x.c[i] : x.a[i]);
          end
        end
        FN_ROTXY, FN_ROTXZ, FN_ROTYZ: y.r = x.a;
        FN_ABS: begin
          for (int i = 0; i < 3; i++) begin
            y.r[i] = sat_w(x.a[i][31] ? -72'(x.a[i]) : 72'(x.a[i]));
          end
        end
        FN_DIFF: begin
          for (int i = 0; i < 3; i++) begin
            y.r[i] = sat_w(x.d[i][31] ? -72'(x.d[i]) : 72'(x.d[i]));
          end
        end
        FN_EQUAL: begin
          y.eq = near_zero(33'(x.a[0]) - 33'(x.b[0]), eps) &&
                 near_zero(33'(x.a[1]) - 33'(x.b[1]), eps) &&
                 near_zero(33'(x.a[2]) - 33'(x.b[2]), eps);
        end
        default: begin
        end
      endcase
    end

    // Fold the reduced angle into [-pi/2, pi/2] and seed the CORDIC.
    if (k == ST_FOLD) begin
      za = x.zneg ? -ang_t'(x.zrem) : ang_t'(x.zrem);
      if (za > PI_Q30) za = za - TWO_PI_A;
      if (za < -PI_Q30) za = za + TWO_PI_A;
      y.flip = 1'b0;
      if (za > HALF_PI_Q30) begin
        za     = za - PI_Q30;
        y.flip = 1'b1;
      end else if (za < -HALF_PI_Q30) begin
        za     = za + PI_Q30;
        y.flip = 1'b1;
      end
      y.z  = za;
      y.cx = GAIN_Q30;
      y.cy = '0;
    end

    if (k >= ST_CORD0 && k < ST_CORD0 + ROT_STEPS) begin
      j  = k - ST_CORD0;
      at = $signed(36'(ATAN_Q30[j]));
      if (x.z >= 0) begin
        nx   = x.cx - (x.cy >>> j);
        y.cy = x.cy + (x.cx >>> j);
        y.z  = x.z - at;
      end else begin
        nx   = x.cx + (x.cy >>> j);
        y.cy = x.cy - (x.cx >>> j);
        y.z  = x.z + at;
      end
      y.cx = nx;
    end

    if (k == ST_ROTSEL) begin
      y.cs = x.flip ? -x.cx : x.cx;
      y.sn = x.flip ? -x.cy : x.cy;
      unique case (func_e'(x.func))
        FN_ROTXY: begin y.rp = x.a[0]; y.rq = x.a[1]; end
        FN_ROTXZ: begin y.rp = x.a[0]; y.rq = x.a[2]; end
        FN_ROTYZ: begin y.rp = x.a[1]; y.rq = x.a[2]; end
        default: begin y.rp = '0; y.rq = '0; end
      endcase
    end

    if (k == ST_ROTMUL) begin
      y.rm[0] = 68'(x.rp) * 68'(x.cs);
      y.rm[1] = 68'(x.rq) * 68'(x.sn);
      y.rm[2] = 68'(x.rp) * 68'(x.sn);
      y.rm[3] = 68'(x.rq) * 68'(x.cs);
    end

    if (k == ST_ROTSUM) begin
      np = sat_w(72'((x.rm[0] - x.rm[1]) >>> TRIG_FRAC));
      nq = sat_w(72'((x.rm[2] + x.rm[3]) >>> TRIG_FRAC));
      unique case (func_e'(x.func))
        FN_ROTXY: begin y.r[0] = np; y.r[1] = nq; end
        FN_ROTXZ: begin y.r[0] = np; y.r[2] = nq; end
        FN_ROTYZ: begin y.r[1] = np; y.r[2] = nq; end
        default: begin
        end
      endcase
    end

    // Integer square root of the 64-bit sum, one result bit per stage.
    if (k >= ST_SQRT0 && k < ST_SQRT0 + SQRT_STEPS) begin
      j    = k - ST_SQRT0;
      bitv = 64'd1 << (2 * (SQRT_STEPS - 1 - j));
      tsum = 65'(x.sroot) + 65'(bitv);
      if (65'(x.ssum) >= tsum) begin
        y.ssum  = x.ssum - tsum[63:0];
        y.sroot = (x.sroot >> 1) + bitv;
      end else begin
        y.sroot = x.sroot >> 1;
      end
    end

    if (k == ST_DIVSET) begin
      len = x.sroot[31:0];
      if (x.func == FN_LEN || x.func == FN_DIST) begin
        y.so = len[31] ? WMAX : word_t'(len);
      end
      for (int i = 0; i < 3; i++) dsg[i] = 33'(x.s);
      y.guard = 1'b0;
      unique case (func_e'(x.func))
        FN_DIV: begin
          for (int i = 0; i < 3; i++) dsg[i] = 33'(x.b[i]);
          y.guard = near_zero(33'(x.b[0]), eps) || near_zero(33'(x.b[1]), eps) ||
                    near_zero(33'(x.b[2]), eps);
        end
        FN_DIVS: y.guard = near_zero(33'(x.s), eps);
        FN_NORM: begin
          for (int i = 0; i < 3; i++) dsg[i] = $signed({1'b0, len});
          y.guard = (len == 32'd0) || (len < 32'(eps));
        end
        default: begin
        end
      endcase
      for (int i = 0; i < 3; i++) begin
        y.num[i]  = 48'(x.a[i][31] ? 33'(-33'(x.a[i])) : 33'(x.a[i])) << FRAC_BITS;
        y.den[i]  = dsg[i][32] ? 33'(-dsg[i]) : 33'(dsg[i]);
        y.qneg[i] = x.a[i][31] ^ dsg[i][32];
        y.ovf[i]  = 65'(y.num[i]) >= (65'(y.den[i]) << 32);
        y.q[i]    = '0;
      end
    end

    // Restoring division, one quotient bit per stage in three lanes.
    if (k >= ST_DIV0 && k < ST_DIV0 + DIV_STEPS) begin
      j = DIV_STEPS - 1 - (k - ST_DIV0);
      for (int i = 0; i < 3; i++) begin
        dd = 64'(x.den[i]) << j;
        if (64'(x.num[i]) >= dd) begin
          y.num[i]  = x.num[i] - dd[47:0];
          y.q[i][j] = 1'b1;
        end
      end
    end

    if (k == ST_LAST) begin
      if (x.func == FN_DIV || x.func == FN_DIVS || x.func == FN_NORM) begin
        for (int i = 0; i < 3; i++) begin
          if (x.guard) begin
            y.r[i] = x.a[i];
          end else if (x.ovf[i]) begin
            y.r[i] = x.qneg[i] ? WMIN : WMAX;
          end else if (x.qneg[i]) begin
            y.r[i] = (x.q[i] > 32'h8000_0000) ? WMIN : word_t'(-x.q[i]);
          end else begin
            y.r[i] = x.q[i][31] ? WMAX : word_t'(x.q[i]);
          end
        end
      end
    end

    return y;
  endfunction

  // A stage loads when it is empty or its content moves on.
  always_comb begin
    adv[NST] = m_axis_tready_i;
    for (int k = NST - 1; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign s_axis_tready_o = adv[0];

  always_comb begin
    st_d[ST_IN]      = '0;
    st_d[ST_IN].func = s_axis_tuser_i;
    for (int i = 0; i < 3; i++) begin
      st_d[ST_IN].a[i] = s_axis_tdata_i[32*i +: 32];
      st_d[ST_IN].b[i] = s_axis_tdata_i[32*(i+3) +: 32];
      st_d[ST_IN].c[i] = s_axis_tdata_i[32*(i+6) +: 32];
    end
    st_d[ST_IN].s = s_axis_tdata_i[32*9 +: 32];
    for (int k = 1; k < NST; k++) begin
      st_d[k] = stage_fn(k, st_q[k-1], eps_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      eps_q <= EPS_BITS'(EPS_RESET);
    end else begin
      if (cfg_we_i) begin
        eps_q <= cfg_wdata_i;
      end
      if (adv[0]) begin
        vld_q[0] <= s_axis_tvalid_i;
      end
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NST; k++) begin
      if (adv[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign m_axis_tvalid_o = vld_q[ST_LAST];
  assign m_axis_tdata_o  = {6'd0, st_q[ST_LAST].guard, st_q[ST_LAST].eq,
                            st_q[ST_LAST].so, st_q[ST_LAST].r[2],
                            st_q[ST_LAST].r[1], st_q[ST_LAST].r[0]};

endmodule

// File: src/v3au_checker.sv
module v3au_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [135:0] m_axis_tdata_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its bits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // Only equality raises is_equal; only divisions and normalize raise the guard.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[128] && m_axis_tdata_o[129]))
    else $error("equality and guard flags both set");

  // The equality operation leaves every numeric field at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[128] |-> m_axis_tdata_o[127:0] == 128'd0)
    else $error("equality result carries numeric data");

  // Divisions and normalize never produce a scalar result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[129] |-> m_axis_tdata_o[127:96] == 32'd0)
    else $error("guarded result carries a scalar");

endmodule

bind vector3_arithmetic_unit_top v3au_checker u_v3au_checker (.*);
